[sv/phong_specular_shade_core_assert.svh]
// assertion macros for the specular shading core
`ifndef PHONG_SPECULAR_SHADE_CORE_ASSERT_SVH
`define PHONG_SPECULAR_SHADE_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define PSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pss check failed");

// next-cycle implication, also checked through reset
`define PSS_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pss check failed");

`endif

[sv/pss_pkg.sv]
package pss_pkg;

  // register indexes
  localparam logic REG_SPEC_COEFF = 1'b0;
  localparam logic REG_SHINE_EXP  = 1'b1;

  localparam logic [15:0] SPEC_COEFF_RST = 16'd4096;
  localparam logic [7:0]  SHINE_EXP_RST  = 8'd1;

  localparam logic [14:0] Q14_ONE = 15'd16384;
  localparam logic [14:0] Q14_MAX = 15'd32767;
  localparam logic [15:0] OUT_MAX = 16'hffff;

  localparam int POW_STAGES = 8;

  typedef struct packed {
    logic        [15:0] light_r;
    logic        [15:0] light_g;
    logic        [15:0] light_b;
    logic signed [15:0] ray_x;
    logic signed [15:0] ray_y;
    logic signed [15:0] ray_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic signed [15:0] view_z;
  } pss_in_t;

  typedef struct packed {
    logic [15:0] spec_r;
    logic [15:0] spec_g;
    logic [15:0] spec_b;
  } pss_out_t;

  // word moving through the power and scale stages
  typedef struct packed {
    logic        black;
    logic [14:0] acc;
    logic [14:0] base;
    logic [15:0] light_r;
    logic [15:0] light_g;
    logic [15:0] light_b;
  } pss_pow_t;

  // pipeline control shared by every stage
  typedef struct packed {
    logic en;
  } pss_ctl_t;

  // q1.14 multiply, round half up, clamp at the top
  function automatic logic [14:0] mul_q14_sat(input logic [14:0] a, input logic [14:0] b);
    logic [29:0] prod;
    logic [30:0] rnd;
    begin
      prod = a * b;
      rnd  = {1'b0, prod} + 31'd8192;
      if (rnd[30:14] > {2'b00, Q14_MAX}) begin
        mul_q14_sat = Q14_MAX;
      end else begin
        mul_q14_sat = rnd[28:14];
      end
    end
  endfunction

endpackage

[sv/phong_specular_shade_core.sv]
// channel   direction  handshake            word
// in        to core    in_valid/in_stall    in_data   (pss_in_t)
// out       from core  out_valid/out_stall  out_data  (pss_out_t)
// cfg       to core    apb psel/penable     pwdata    (spec_coeff, shine_exponent)
//
// one word accepted per cycle while no result is held by out_stall
// a word passes the dot product, eight square-and-multiply and scale stages
// rst is synchronous; it clears the valid bits and loads the register defaults
// a stalled result freezes the whole pipeline; in_stall follows at once
module phong_specular_shade_core
  import pss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  pss_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pss_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] spec_coeff;
  logic [7:0]  shine_exponent;
  pss_ctl_t    ctl;
  logic        refl_valid;
  pss_pow_t    refl_data;
  logic        pow_valid;
  pss_pow_t    pow_data;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      spec_coeff     <= SPEC_COEFF_RST;
      shine_exponent <= SHINE_EXP_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SPEC_COEFF: spec_coeff     <= pwdata[15:0];
        REG_SHINE_EXP:  shine_exponent <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SPEC_COEFF: prdata = {16'd0, spec_coeff};
      REG_SHINE_EXP:  prdata = {24'd0, shine_exponent};
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // pipeline advance
  assign ctl.en   = !(out_valid && out_stall);
  assign in_stall = !ctl.en;

  pss_reflect u_reflect (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (refl_valid),
    .out_data  (refl_data)
  );

  pss_power u_power (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .shine_exponent (shine_exponent),
    .in_valid       (refl_valid),
    .in_data        (refl_data),
    .out_valid      (pow_valid),
    .out_data       (pow_data)
  );

  pss_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .spec_coeff (spec_coeff),
    .in_valid   (pow_valid),
    .in_data    (pow_data),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

`include "phong_specular_shade_core_assert.svh"

  `PSS_ASSERT_NOW(a_stall_backs_up, clk, rst, out_valid && out_stall, in_stall)
  `PSS_ASSERT_NOW(a_free_flow, clk, rst, !out_stall, !in_stall)
  `PSS_ASSERT_NEXT(a_reset_empty, clk, rst, !out_valid && !pow_valid && !refl_valid)

endmodule

[sv/pss_reflect.sv]
module pss_reflect
  import pss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  pss_ctl_t ctl,
  input  logic     in_valid,
  input  pss_in_t  in_data,
  output logic     out_valid,
  output pss_pow_t out_data
);

  logic [5:0] vld;
  pss_in_t    s1, s2, s3, s4, s5;

  logic signed [31:0] m1 [3];
  logic signed [32:0] d2;
  logic signed [48:0] p3 [3];
  logic signed [22:0] r4 [3];
  logic signed [38:0] q5 [3];

  logic signed [49:0] pr [3];
  logic signed [22:0] r_next [3];
  logic signed [40:0] f_sum;
  logic signed [40:0] f_rnd;
  logic        [26:0] b_wide;
  logic        [14:0] b_next;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  // rounding of the reflected vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr[i]     = {p3[i][48], p3[i]} + (50'sd1 <<< 26);
      r_next[i] = pr[i][49:27];
    end
    r_next[0] = r_next[0] - 23'(s3.ray_x);
    r_next[1] = r_next[1] - 23'(s3.ray_y);
    r_next[2] = r_next[2] - 23'(s3.ray_z);
  end

  // highlight factor, round and clamp
  always_comb begin
    f_sum  = 41'(q5[0]) + 41'(q5[1]) + 41'(q5[2]);
    f_rnd  = f_sum + 41'sd8192;
    b_wide = f_rnd[40:14];
    if (b_wide > 27'(Q14_MAX)) begin
      b_next = Q14_MAX;
    end else begin
      b_next = b_wide[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      // stage 1: ray dot normal products
      s1    <= in_data;
      m1[0] <= in_data.ray_x * in_data.norm_x;
      m1[1] <= in_data.ray_y * in_data.norm_y;
      m1[2] <= in_data.ray_z * in_data.norm_z;
      // stage 2: sum
      s2 <= s1;
      d2 <= 33'(m1[0]) + 33'(m1[1]) + 33'(m1[2]);
      // stage 3: scale normal by the dot
      s3    <= s2;
      p3[0] <= d2 * s2.norm_x;
      p3[1] <= d2 * s2.norm_y;
      p3[2] <= d2 * s2.norm_z;
      // stage 4: reflected vector
      s4 <= s3;
      r4 <= r_next;
      // stage 5: reflection dot viewer products
      s5    <= s4;
      q5[0] <= r4[0] * s4.view_x;
      q5[1] <= r4[1] * s4.view_y;
      q5[2] <= r4[2] * s4.view_z;
      // stage 6: factor into the power word
      out_data.black   <= f_sum[40];
      out_data.acc     <= Q14_ONE;
      out_data.base    <= b_next;
      out_data.light_r <= s5.light_r;
      out_data.light_g <= s5.light_g;
      out_data.light_b <= s5.light_b;
    end
  end

  assign out_valid = vld[5];

endmodule

[sv/pss_power.sv]
module pss_power
  import pss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  pss_ctl_t   ctl,
  input  logic [7:0] shine_exponent,
  input  logic       in_valid,
  input  pss_pow_t   in_data,
  output logic       out_valid,
  output pss_pow_t   out_data
);

  logic [POW_STAGES-1:0] vld;
  pss_pow_t              stg [POW_STAGES];
  pss_pow_t              nxt [POW_STAGES];

  // one square-and-multiply step per stage, exponent bit i in stage i
  always_comb begin
    for (int i = 0; i < POW_STAGES; i++) begin
      nxt[i] = (i == 0) ? in_data : stg[(i == 0) ? 0 : i - 1];
      if (shine_exponent[i]) begin
        nxt[i].acc = mul_q14_sat(nxt[i].acc, nxt[i].base);
      end
      nxt[i].base = mul_q14_sat(nxt[i].base, nxt[i].base);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.en) begin
      vld <= {vld[POW_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < POW_STAGES; i++) begin
        stg[i] <= nxt[i];
      end
    end
  end

  assign out_valid = vld[POW_STAGES-1];
  assign out_data  = stg[POW_STAGES-1];

endmodule

[sv/pss_scale.sv]
module pss_scale
  import pss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  pss_ctl_t    ctl,
  input  logic [15:0] spec_coeff,
  input  logic        in_valid,
  input  pss_pow_t    in_data,
  output logic        out_valid,
  output pss_out_t    out_data
);

  logic [1:0]  vld;
  logic [30:0] t;
  pss_pow_t    s1;
  logic [15:0] ch_next [3];
  logic [15:0] lights  [3];

  // per channel: round, clamp, black
  always_comb begin
    logic [46:0] m;
    logic [47:0] mr;
    lights[0] = s1.light_r;
    lights[1] = s1.light_g;
    lights[2] = s1.light_b;
    for (int i = 0; i < 3; i++) begin
      m  = t * lights[i];
      mr = {1'b0, m} + (48'd1 << 25);
      if (s1.black) begin
        ch_next[i] = '0;
      end else if (mr[47:26] > 22'(OUT_MAX)) begin
        ch_next[i] = OUT_MAX;
      end else begin
        ch_next[i] = mr[41:26];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.en) begin
      vld <= {vld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      // power times coefficient
      s1 <= in_data;
      t  <= in_data.acc * spec_coeff;
      // times light, into the output register
      out_data.spec_r <= ch_next[0];
      out_data.spec_g <= ch_next[1];
      out_data.spec_b <= ch_next[2];
    end
  end

  assign out_valid = vld[1];

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import pss_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pss_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pss_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  phong_specular_shade_core u_dut (.*);

  always #1 clk = ~clk;

  // shading settings mirrored from the register file
  logic [15:0] coeff_q;
  logic [7:0]  shine_q;

  pss_in_t  pending_words[$];
  pss_out_t expected_shades[$];
  int       mismatch_count = 0;
  int       stray_count = 0;
  bit       idle_enable = 1'b1;
  int       in_gap = 0;
  int       out_hold = 0;
  int       quiet_cycles = 0;

  // round half up, arithmetic shift
  function automatic longint round_shift(input longint x, input int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint q14_mul_clamp(input longint a, input longint b);
    longint r;
    r = round_shift(a * b, 14);
    return (r > 32767) ? 32767 : r;
  endfunction

  function automatic logic [15:0] scale_channel(input longint pw, input logic [15:0] light);
    longint r;
    r = round_shift(pw * longint'(coeff_q) * longint'(light), 26);
    if (r > 65535) r = 65535;
    if (r < 0) r = 0;
    return r[15:0];
  endfunction

  function automatic pss_out_t shade_highlight(input pss_in_t w);
    longint   ray[3];
    longint   nrm[3];
    longint   vw[3];
    longint   refl[3];
    longint   dot_rn;
    longint   factor;
    longint   base;
    longint   acc;
    pss_out_t res;
    ray = '{longint'(w.ray_x), longint'(w.ray_y), longint'(w.ray_z)};
    nrm = '{longint'(w.norm_x), longint'(w.norm_y), longint'(w.norm_z)};
    vw  = '{longint'(w.view_x), longint'(w.view_y), longint'(w.view_z)};
    dot_rn = 0;
    factor = 0;
    for (int i = 0; i < 3; i++) dot_rn += ray[i] * nrm[i];
    for (int i = 0; i < 3; i++) refl[i] = round_shift(2 * dot_rn * nrm[i], 28) - ray[i];
    for (int i = 0; i < 3; i++) factor += refl[i] * vw[i];
    if (factor < 0) return '0;
    base = round_shift(factor, 14);
    if (base > 32767) base = 32767;
    acc = 16384;
    for (int i = 0; i < 8; i++) begin
      if (shine_q[i]) acc = q14_mul_clamp(acc, base);
      base = q14_mul_clamp(base, base);
    end
    res.spec_r = scale_channel(acc, w.light_r);
    res.spec_g = scale_channel(acc, w.light_g);
    res.spec_b = scale_channel(acc, w.light_b);
    return res;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_shades.push_back(shade_highlight(in_data));
        void'(pending_words.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else if (pending_words.size() > (in_valid && !in_stall ? 1 : 0)) begin
        in_valid <= 1'b1;
        in_data <= pending_words[(in_valid && !in_stall) ? 1 : 0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall and result check
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_shades.size() == 0) begin
          stray_count++;
          if (mismatch_count + stray_count <= 10)
            $display("unexpected word %h", out_data);
        end else begin
          pss_out_t exp_w;
          exp_w = expected_shades.pop_front();
          if (exp_w !== out_data) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp r=%h g=%h b=%h got r=%h g=%h b=%h",
                       exp_w.spec_r, exp_w.spec_g, exp_w.spec_b,
                       out_data.spec_r, out_data.spec_g, out_data.spec_b);
          end
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_hold <= $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0
                      : quiet_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd4 * REG_SPEC_COEFF) coeff_q = data[15:0];
    else shine_q = data[7:0];
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_shades.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_vec();
    case ($urandom_range(0, 3))
      0: return 16'($signed($urandom_range(0, 32767)) - 16384);
      1: return $urandom();
      2: return 16'(16384 - $urandom_range(0, 1024));
      default: return 16'($urandom_range(0, 4096)) - 16'd2048;
    endcase
  endfunction

  function automatic pss_in_t rand_word();
    pss_in_t w;
    w = $urandom();
    w.light_r = $urandom(); w.light_g = $urandom(); w.light_b = $urandom();
    if ($urandom_range(0, 3) != 0) begin
      // random normal and ray, view near the ray mirrored in x and y only
      w.norm_x = rand_vec(); w.norm_y = rand_vec(); w.norm_z = rand_vec();
      w.ray_x = rand_vec(); w.ray_y = rand_vec(); w.ray_z = rand_vec();
      w.view_x = -w.ray_x + 16'($urandom_range(0, 200)) - 16'd100;
      w.view_y = -w.ray_y + 16'($urandom_range(0, 200)) - 16'd100;
      w.view_z = w.ray_z + 16'($urandom_range(0, 200)) - 16'd100;
    end
    return w;
  endfunction

  function automatic pss_in_t mk_word(input logic [15:0] lr, lg, lb,
                                      input logic [15:0] rx, ry, rz, nx, ny, nz,
                                      vx, vy, vz);
    return {lr, lg, lb, rx, ry, rz, nx, ny, nz, vx, vy, vz};
  endfunction

  initial begin
    int shine_set[6];
    int coeff_set[6];
    shine_set = '{1, 255, 2, 8, 37, 128};
    coeff_set = '{65535, 0, 4096, 12345, 1, 30000};
    coeff_q = SPEC_COEFF_RST;
    shine_q = SHINE_EXP_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words under reset settings: head-on highlight, black, zero, extremes
    pending_words.push_back(mk_word(16'd4096, 16'd4096, 16'd4096, 0, 0, -16384,
                                    0, 0, 16384, 0, 0, 16384));
    pending_words.push_back(mk_word(16'hffff, 16'hffff, 16'hffff, 0, 0, -16384,
                                    0, 0, 16384, 0, 0, -16384));
    pending_words.push_back(mk_word(16'hffff, 0, 16'h1234, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(mk_word(16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h8000,
                                    16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                    16'h8000, 16'h8000, 16'h8000));
    pending_words.push_back(mk_word(16'hffff, 16'h8000, 1, 16'h7fff, 16'h7fff, 16'h7fff,
                                    16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                    16'h7fff));
    pending_words.push_back(mk_word(16'h5555, 16'haaaa, 16'hffff, 16'h7fff, 16'h8000,
                                    16'h0001, 16'h8000, 16'h7fff, 16'hffff, 16'h8000,
                                    16'h7fff, 16'h0001));
    for (int i = 0; i < 10; i++) pending_words.push_back(rand_word());
    wait_drained();

    // pressure: sender waits for the pipeline to empty between bursts of 130 words
    for (int p = 0; p < 6; p++) begin
      reg_write(3'd4 * REG_SPEC_COEFF, coeff_set[p]);
      reg_write(3'd4 * REG_SHINE_EXP, shine_set[p]);
      for (int i = 0; i < 130; i++) pending_words.push_back(rand_word());
      if (p == 5) idle_enable = 1'b0;
      wait_drained();
    end

    if (mismatch_count == 0 && stray_count == 0 && expected_shades.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/pss_pkg.sv
sv/pss_reflect.sv
sv/pss_power.sv
sv/pss_scale.sv
sv/phong_specular_shade_core.sv
dv/tb.sv
